// File: rtl/cbf_pkg.sv
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants of the cubic Bezier flattener
// Fixed-point widths, item structs, stack frame, sequencer states and the
// control and status groups that pass between the sequencer and datapath.
// ----------------------------------------------------------------------------
package cbf_pkg;

  // Depth limit and coordinate formats
  localparam int MAX_DEPTH  = 4;
  localparam int COORD_BITS = 24;
  localparam int GUARD_BITS = 16;
  localparam int TOL_BITS   = 16;

  // Internal widths
  localparam int WIDE_BITS  = COORD_BITS + GUARD_BITS;
  localparam int DIFF_BITS  = WIDE_BITS + 1;
  localparam int SCALE_BITS = TOL_BITS + GUARD_BITS;
  localparam int QT_BITS    = 2 * SCALE_BITS;
  localparam int MUL_BITS   = 32;
  localparam int EXT_BITS   = 2 * MUL_BITS;
  localparam int SUM_BITS   = EXT_BITS + 1;

  // Stack sizing: one pending second half per level
  localparam int STACK_SLOTS = MAX_DEPTH + 1;
  localparam int SLOT_BITS   = (STACK_SLOTS > 1) ? $clog2(STACK_SLOTS) : 1;
  localparam int TOP_BITS    = $clog2(STACK_SLOTS + 1);
  localparam int LEVEL_BITS  = $clog2(MAX_DEPTH + 2);

  typedef logic signed [WIDE_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0] diff_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] x3;
    logic signed [COORD_BITS-1:0] y3;
    logic signed [COORD_BITS-1:0] x4;
    logic signed [COORD_BITS-1:0] y4;
    logic [TOL_BITS-1:0]          tolerance;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         last;
  } out_item_t;

  // One pending piece: four points and its level
  typedef struct packed {
    coord_t [3:0]          px;
    coord_t [3:0]          py;
    logic [LEVEL_BITS-1:0] level;
  } frame_t;

  typedef enum logic {
    OP_HALF,
    OP_DIFF
  } alu_op_t;

  // Which midpoint or difference the shared unit produces this cycle
  typedef enum logic [3:0] {
    ST_NONE,
    ST_12,
    ST_23,
    ST_34,
    ST_14,
    ST_123,
    ST_234,
    ST_M,
    ST_DIFF
  } step_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TOL,
    S_CHECK,
    S_H23,
    S_H34,
    S_H14,
    S_H123,
    S_H234,
    S_HM,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_CMP,
    S_EMIT,
    S_POP,
    S_LOAD,
    S_FINAL
  } state_t;

  typedef struct packed {
    logic  idle;
    logic  load_item;
    logic  sq_tol;
    step_t step;
    logic  sq_x;
    logic  sq_y;
    logic  split;
    logic  pop_rd;
    logic  load_pop;
    logic  emit_pt;
    logic  emit_final;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic deep;
    logic flat;
    logic stack_empty;
  } stat_t;

  // Sign-extend a coordinate and add the guard fraction bits
  function automatic coord_t widen(input logic signed [COORD_BITS-1:0] v);
    coord_t w;
    w = coord_t'(v);
    return w <<< GUARD_BITS;
  endfunction

  // Magnitude of a difference as an unsigned value of the same width
  function automatic logic [DIFF_BITS-1:0] mag_of(input diff_t d);
    logic [DIFF_BITS-1:0] u;
    u = d[DIFF_BITS-1] ? DIFF_BITS'(-d) : DIFF_BITS'(d);
    return u;
  endfunction

endpackage

// File: rtl/cbf_stack.sv
// ----------------------------------------------------------------------------
// cbf_stack: subdivision stack memory
// One frame per row, one write and one registered read per cycle.
// Contents are undefined until written.
// ----------------------------------------------------------------------------
module cbf_stack (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [cbf_pkg::SLOT_BITS-1:0] wr_addr,
  input  cbf_pkg::frame_t               wr_data,
  input  logic                          rd_en,
  input  logic [cbf_pkg::SLOT_BITS-1:0] rd_addr,
  output cbf_pkg::frame_t               rd_data_r
);

  cbf_pkg::frame_t mem [cbf_pkg::STACK_SLOTS];

  // Write a pushed frame
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the popped frame into the output register
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/cbf_unit.sv
// ----------------------------------------------------------------------------
// cbf_unit: shared arithmetic unit
// Two-lane halving adder / subtractor for x and y, and one 32-bit squarer.
// Results are registered by the datapath.
// ----------------------------------------------------------------------------
module cbf_unit (
  input  cbf_pkg::alu_op_t             op,
  input  cbf_pkg::coord_t              a_x,
  input  cbf_pkg::coord_t              b_x,
  input  cbf_pkg::coord_t              a_y,
  input  cbf_pkg::coord_t              b_y,
  input  logic [cbf_pkg::MUL_BITS-1:0] mul_a,
  output cbf_pkg::diff_t               res_x,
  output cbf_pkg::diff_t               res_y,
  output logic [cbf_pkg::EXT_BITS-1:0] prod
);

  cbf_pkg::diff_t sum_x;
  cbf_pkg::diff_t sum_y;

  // Add or subtract on both lanes
  always_comb begin
    if (op == cbf_pkg::OP_DIFF) begin
      sum_x = cbf_pkg::diff_t'(a_x) - cbf_pkg::diff_t'(b_x);
      sum_y = cbf_pkg::diff_t'(a_y) - cbf_pkg::diff_t'(b_y);
    end else begin
      sum_x = cbf_pkg::diff_t'(a_x) + cbf_pkg::diff_t'(b_x);
      sum_y = cbf_pkg::diff_t'(a_y) + cbf_pkg::diff_t'(b_y);
    end
  end

  // Halve with floor rounding for midpoints, pass differences whole
  assign res_x = (op == cbf_pkg::OP_DIFF) ? sum_x : (sum_x >>> 1);
  assign res_y = (op == cbf_pkg::OP_DIFF) ? sum_y : (sum_y >>> 1);

  // Square the selected magnitude
  assign prod = cbf_pkg::EXT_BITS'(mul_a) * cbf_pkg::EXT_BITS'(mul_a);

endmodule

// File: rtl/cbf_seq.sv
// ----------------------------------------------------------------------------
// cbf_seq: flattening sequencer
// Steps the shared unit through the midpoints, difference, squares and
// flatness compare of each piece, then splits, emits or pops.
// ----------------------------------------------------------------------------
module cbf_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  cbf_pkg::stat_t stat,
  output cbf_pkg::ctrl_t ctrl
);

  cbf_pkg::state_t state_r;
  cbf_pkg::state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbf_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cbf_pkg::S_IDLE:  if (stat.in_valid) state_nxt = cbf_pkg::S_TOL;
      cbf_pkg::S_TOL:   state_nxt = cbf_pkg::S_CHECK;
      cbf_pkg::S_CHECK: state_nxt = stat.deep ? cbf_pkg::S_EMIT : cbf_pkg::S_H23;
      cbf_pkg::S_H23:   state_nxt = cbf_pkg::S_H34;
      cbf_pkg::S_H34:   state_nxt = cbf_pkg::S_H14;
      cbf_pkg::S_H14:   state_nxt = cbf_pkg::S_H123;
      cbf_pkg::S_H123:  state_nxt = cbf_pkg::S_H234;
      cbf_pkg::S_H234:  state_nxt = cbf_pkg::S_HM;
      cbf_pkg::S_HM:    state_nxt = cbf_pkg::S_DIFF;
      cbf_pkg::S_DIFF:  state_nxt = cbf_pkg::S_SQX;
      cbf_pkg::S_SQX:   state_nxt = cbf_pkg::S_SQY;
      cbf_pkg::S_SQY:   state_nxt = cbf_pkg::S_CMP;
      cbf_pkg::S_CMP:   state_nxt = stat.flat ? cbf_pkg::S_EMIT : cbf_pkg::S_CHECK;
      cbf_pkg::S_EMIT: begin
        if (stat.out_free) begin
          state_nxt = stat.stack_empty ? cbf_pkg::S_FINAL : cbf_pkg::S_POP;
        end
      end
      cbf_pkg::S_POP:   state_nxt = cbf_pkg::S_LOAD;
      cbf_pkg::S_LOAD:  state_nxt = cbf_pkg::S_CHECK;
      cbf_pkg::S_FINAL: if (stat.out_free) state_nxt = cbf_pkg::S_IDLE;
      default:          state_nxt = cbf_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl      = '0;
    ctrl.step = cbf_pkg::ST_NONE;
    unique case (state_r)
      cbf_pkg::S_IDLE: begin
        ctrl.idle      = 1'b1;
        ctrl.load_item = stat.in_valid;
      end
      cbf_pkg::S_TOL:   ctrl.sq_tol = 1'b1;
      cbf_pkg::S_CHECK: ctrl.step = cbf_pkg::ST_12;
      cbf_pkg::S_H23:   ctrl.step = cbf_pkg::ST_23;
      cbf_pkg::S_H34:   ctrl.step = cbf_pkg::ST_34;
      cbf_pkg::S_H14:   ctrl.step = cbf_pkg::ST_14;
      cbf_pkg::S_H123:  ctrl.step = cbf_pkg::ST_123;
      cbf_pkg::S_H234:  ctrl.step = cbf_pkg::ST_234;
      cbf_pkg::S_HM:    ctrl.step = cbf_pkg::ST_M;
      cbf_pkg::S_DIFF:  ctrl.step = cbf_pkg::ST_DIFF;
      cbf_pkg::S_SQX:   ctrl.sq_x = 1'b1;
      cbf_pkg::S_SQY:   ctrl.sq_y = 1'b1;
      cbf_pkg::S_CMP:   ctrl.split = !stat.flat;
      cbf_pkg::S_EMIT:  ctrl.emit_pt = stat.out_free;
      cbf_pkg::S_POP:   ctrl.pop_rd = 1'b1;
      cbf_pkg::S_LOAD:  ctrl.load_pop = 1'b1;
      cbf_pkg::S_FINAL: ctrl.emit_final = stat.out_free;
      default: begin
        ctrl      = '0;
        ctrl.step = cbf_pkg::ST_NONE;
      end
    endcase
  end

endmodule

// File: rtl/cubic_bezier_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener: adaptive de Casteljau cubic curve flattener
// Takes one cubic curve and a tolerance per item and returns its line
// endpoints in order, then the curve end point flagged last.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one curve: four Q15.8
//   control points and a Q8.8 tolerance. in_ready is high only while no
//   curve is in work, so one curve is flattened at a time.
//   Output channel out_valid/out_ready/out_data carries the endpoints,
//   one per item, with last set on the final repeated end point.
//   Each piece that is tested passes through the shared halving adder and
//   squarer; a piece past the depth limit is emitted untested instead.
//   Each emitted endpoint but the last is followed by a pop of the next
//   frame. A curve gives from 2 results (flat at once) to 33 (split fully).
//   The next curve is taken the cycle after the last result is loaded into
//   the output register.
//   A stalled receiver holds the sequencer at its next emit; the finished
//   result waits in the output register.
//   Reset (synchronous, rst_n low) empties the stack, drops any pending
//   result and returns to idle. The stack memory needs no clearing pass.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cbf_pkg::out_item_t out_data
);

  cbf_pkg::ctrl_t ctrl;
  cbf_pkg::stat_t stat;

  // Working piece and per-piece temporaries
  cbf_pkg::frame_t cur_r;
  cbf_pkg::coord_t h12x_r, h12y_r, h23x_r, h23y_r, h34x_r, h34y_r;
  cbf_pkg::coord_t h14x_r, h14y_r, h123x_r, h123y_r, h234x_r, h234y_r;
  cbf_pkg::coord_t hmx_r, hmy_r;
  cbf_pkg::diff_t  dx_r, dy_r;
  logic [cbf_pkg::EXT_BITS-1:0] sx_r;
  logic [cbf_pkg::SUM_BITS-1:0] sum_r;
  logic                         big_r;
  logic [cbf_pkg::QT_BITS-1:0]  qt_r;
  logic [cbf_pkg::TOL_BITS-1:0] tol_r;
  logic signed [cbf_pkg::COORD_BITS-1:0] ex_r, ey_r;

  logic [cbf_pkg::TOP_BITS-1:0] stack_top_r;
  logic [cbf_pkg::TOP_BITS-1:0] top_m1;
  logic                         out_valid_r;
  cbf_pkg::out_item_t           out_data_r;

  // Shared unit connections
  cbf_pkg::alu_op_t             op;
  cbf_pkg::coord_t              a_x, b_x, a_y, b_y;
  logic [cbf_pkg::MUL_BITS-1:0] mul_a;
  cbf_pkg::diff_t               res_x, res_y;
  logic [cbf_pkg::EXT_BITS-1:0] prod;
  logic [cbf_pkg::DIFF_BITS-1:0] magx, magy;
  logic                          hugex, hugey;

  cbf_pkg::frame_t push_frame;
  cbf_pkg::frame_t pop_frame;

  cbf_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  cbf_unit u_unit (
    .op    (op),
    .a_x   (a_x),
    .b_x   (b_x),
    .a_y   (a_y),
    .b_y   (b_y),
    .mul_a (mul_a),
    .res_x (res_x),
    .res_y (res_y),
    .prod  (prod)
  );

  assign top_m1 = stack_top_r - cbf_pkg::TOP_BITS'(1);

  cbf_stack u_stack (
    .clk       (clk),
    .wr_en     (ctrl.split),
    .wr_addr   (stack_top_r[cbf_pkg::SLOT_BITS-1:0]),
    .wr_data   (push_frame),
    .rd_en     (ctrl.pop_rd),
    .rd_addr   (top_m1[cbf_pkg::SLOT_BITS-1:0]),
    .rd_data_r (pop_frame)
  );

  // Status toward the sequencer
  assign stat.in_valid    = in_valid;
  assign stat.out_free    = !out_valid_r || out_ready;
  assign stat.deep        = cur_r.level > cbf_pkg::LEVEL_BITS'(cbf_pkg::MAX_DEPTH);
  assign stat.flat        = !big_r && (sum_r < cbf_pkg::SUM_BITS'(qt_r));
  assign stat.stack_empty = (stack_top_r == '0);

  // Select operands for the shared adder
  always_comb begin
    op  = cbf_pkg::OP_HALF;
    a_x = '0;
    b_x = '0;
    a_y = '0;
    b_y = '0;
    case (ctrl.step)
      cbf_pkg::ST_12: begin
        a_x = cur_r.px[0]; b_x = cur_r.px[1];
        a_y = cur_r.py[0]; b_y = cur_r.py[1];
      end
      cbf_pkg::ST_23: begin
        a_x = cur_r.px[1]; b_x = cur_r.px[2];
        a_y = cur_r.py[1]; b_y = cur_r.py[2];
      end
      cbf_pkg::ST_34: begin
        a_x = cur_r.px[2]; b_x = cur_r.px[3];
        a_y = cur_r.py[2]; b_y = cur_r.py[3];
      end
      cbf_pkg::ST_14: begin
        a_x = cur_r.px[0]; b_x = cur_r.px[3];
        a_y = cur_r.py[0]; b_y = cur_r.py[3];
      end
      cbf_pkg::ST_123: begin
        a_x = h12x_r; b_x = h23x_r;
        a_y = h12y_r; b_y = h23y_r;
      end
      cbf_pkg::ST_234: begin
        a_x = h23x_r; b_x = h34x_r;
        a_y = h23y_r; b_y = h34y_r;
      end
      cbf_pkg::ST_M: begin
        a_x = h123x_r; b_x = h234x_r;
        a_y = h123y_r; b_y = h234y_r;
      end
      cbf_pkg::ST_DIFF: begin
        op  = cbf_pkg::OP_DIFF;
        a_x = h14x_r; b_x = hmx_r;
        a_y = h14y_r; b_y = hmy_r;
      end
      default: begin
        op = cbf_pkg::OP_HALF;
      end
    endcase
  end

  // Magnitudes and range checks of the distance components
  assign magx  = cbf_pkg::mag_of(dx_r);
  assign magy  = cbf_pkg::mag_of(dy_r);
  assign hugex = (cbf_pkg::EXT_BITS'(magx) >> cbf_pkg::MUL_BITS) != '0;
  assign hugey = (cbf_pkg::EXT_BITS'(magy) >> cbf_pkg::MUL_BITS) != '0;

  // Select the squarer operand
  always_comb begin
    if (ctrl.sq_tol) begin
      mul_a = cbf_pkg::MUL_BITS'(cbf_pkg::SCALE_BITS'(tol_r) << cbf_pkg::GUARD_BITS);
    end else if (ctrl.sq_x) begin
      mul_a = cbf_pkg::MUL_BITS'(magx);
    end else if (ctrl.sq_y) begin
      mul_a = cbf_pkg::MUL_BITS'(magy);
    end else begin
      mul_a = '0;
    end
  end

  // Second half goes on the stack, first half stays in work
  always_comb begin
    push_frame.px[0] = hmx_r;
    push_frame.py[0] = hmy_r;
    push_frame.px[1] = h234x_r;
    push_frame.py[1] = h234y_r;
    push_frame.px[2] = h34x_r;
    push_frame.py[2] = h34y_r;
    push_frame.px[3] = cur_r.px[3];
    push_frame.py[3] = cur_r.py[3];
    push_frame.level = cur_r.level + cbf_pkg::LEVEL_BITS'(1);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (ctrl.load_item) begin
      cur_r.px[0] <= cbf_pkg::widen(in_data.x1);
      cur_r.py[0] <= cbf_pkg::widen(in_data.y1);
      cur_r.px[1] <= cbf_pkg::widen(in_data.x2);
      cur_r.py[1] <= cbf_pkg::widen(in_data.y2);
      cur_r.px[2] <= cbf_pkg::widen(in_data.x3);
      cur_r.py[2] <= cbf_pkg::widen(in_data.y3);
      cur_r.px[3] <= cbf_pkg::widen(in_data.x4);
      cur_r.py[3] <= cbf_pkg::widen(in_data.y4);
      cur_r.level <= '0;
      ex_r        <= in_data.x4;
      ey_r        <= in_data.y4;
      tol_r       <= in_data.tolerance;
    end else if (ctrl.split) begin
      cur_r.px[1] <= h12x_r;
      cur_r.py[1] <= h12y_r;
      cur_r.px[2] <= h123x_r;
      cur_r.py[2] <= h123y_r;
      cur_r.px[3] <= hmx_r;
      cur_r.py[3] <= hmy_r;
      cur_r.level <= cur_r.level + cbf_pkg::LEVEL_BITS'(1);
    end else if (ctrl.load_pop) begin
      cur_r <= pop_frame;
    end

    // Capture midpoints and differences from the shared adder
    case (ctrl.step)
      cbf_pkg::ST_12: begin
        h12x_r <= cbf_pkg::coord_t'(res_x);
        h12y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_23: begin
        h23x_r <= cbf_pkg::coord_t'(res_x);
        h23y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_34: begin
        h34x_r <= cbf_pkg::coord_t'(res_x);
        h34y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_14: begin
        h14x_r <= cbf_pkg::coord_t'(res_x);
        h14y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_123: begin
        h123x_r <= cbf_pkg::coord_t'(res_x);
        h123y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_234: begin
        h234x_r <= cbf_pkg::coord_t'(res_x);
        h234y_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_M: begin
        hmx_r <= cbf_pkg::coord_t'(res_x);
        hmy_r <= cbf_pkg::coord_t'(res_y);
      end
      cbf_pkg::ST_DIFF: begin
        dx_r <= res_x;
        dy_r <= res_y;
      end
      default: begin
      end
    endcase

    // Capture squares and the running sum
    if (ctrl.sq_tol) begin
      qt_r <= prod[cbf_pkg::QT_BITS-1:0];
    end
    if (ctrl.sq_x) begin
      sx_r  <= prod;
      big_r <= hugex;
    end
    if (ctrl.sq_y) begin
      sum_r <= {1'b0, sx_r} + {1'b0, prod};
      big_r <= big_r || hugey;
    end

    // Load the output register, dropping guard bits
    if (ctrl.emit_pt) begin
      out_data_r.point_x <= cur_r.px[3][cbf_pkg::WIDE_BITS-1:cbf_pkg::GUARD_BITS];
      out_data_r.point_y <= cur_r.py[3][cbf_pkg::WIDE_BITS-1:cbf_pkg::GUARD_BITS];
      out_data_r.last    <= 1'b0;
    end else if (ctrl.emit_final) begin
      out_data_r.point_x <= ex_r;
      out_data_r.point_y <= ey_r;
      out_data_r.last    <= 1'b1;
    end
  end

  // Stack pointer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stack_top_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.load_item) begin
        stack_top_r <= '0;
      end else if (ctrl.split) begin
        stack_top_r <= stack_top_r + cbf_pkg::TOP_BITS'(1);
      end else if (ctrl.pop_rd) begin
        stack_top_r <= top_m1;
      end
      if (ctrl.emit_pt || ctrl.emit_final) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_ready  = ctrl.idle;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (stack_top_r == '0))
    else $error("idle with pending stack frames");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.split |-> (stack_top_r < cbf_pkg::TOP_BITS'(cbf_pkg::STACK_SLOTS)))
    else $error("stack push beyond its depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.pop_rd |-> (stack_top_r != '0))
    else $error("stack pop while empty");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.emit_pt || ctrl.emit_final) |-> (!out_valid_r || out_ready))
    else $error("result overwrites an item not yet taken");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.emit_final |=> in_ready)
    else $error("final endpoint not followed by idle");
`endif

endmodule

// File: tb/sv/cubic_bezier_flattener_tb.sv
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_tb: self-checking bench for the curve flattener
// Sends cubic curves over the input channel, first from a directed table and
// then at random, and checks every returned endpoint against typed-in results
// or a de Casteljau model in the bench. Sender gaps and receiver stalls change
// by phase, with one long receiver hold-off and drains between phases.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener_tb;

  localparam int MAXC        = 8388607;
  localparam int MINC        = -8388608;
  localparam int PHASE_ITEMS = 98;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_ROWS    = 16;

  // One directed row: the curve, and whether its results are typed in
  typedef struct packed {
    cbf_pkg::in_item_t curve;
    logic              typed;
  } curve_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  cbf_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  cbf_pkg::out_item_t out_data;

  cbf_pkg::out_item_t pending_points[$];
  cbf_pkg::out_item_t want;
  int                 mismatch_count;
  int                 idle_pct;
  int                 stall_pct;
  int                 hold_req;
  curve_row_t         directed_rows[NUM_ROWS];
  int                 idle_by_phase[4]  = '{0, 53, 0, 25};
  int                 stall_by_phase[4] = '{0, 0, 53, 25};

  cubic_bezier_flattener dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Give up after a generous fixed time
  initial begin
    #30000000;
    $display("Verification failed");
    $finish;
  end

  // Floor of the average of two coordinates
  function automatic longint mid_floor(input longint a, input longint b);
    return (a + b) >>> 1;
  endfunction

  // Drop the guard fraction bits, rounding toward minus infinity
  function automatic logic signed [cbf_pkg::COORD_BITS-1:0] drop_guard(input longint v);
    longint r;
    r = v >>> cbf_pkg::GUARD_BITS;
    return r[cbf_pkg::COORD_BITS-1:0];
  endfunction

  // Squared distance strictly below the squared tolerance, saturating
  function automatic bit within_tol(input longint dx, input longint dy,
                                    input logic [63:0] qt);
    logic [63:0] ax;
    logic [63:0] ay;
    logic [63:0] sx;
    logic [63:0] sy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (ax >= 64'h1_0000_0000 || ay >= 64'h1_0000_0000) return 1'b0;
    sx = ax * ax;
    sy = ay * ay;
    if (sx >= qt) return 1'b0;
    return sy < (qt - sx);
  endfunction

  // Flatten one curve depth first and queue its endpoints
  function automatic void flatten_curve(input cbf_pkg::in_item_t c);
    longint      pieces[0:7][0:7];
    int          levels[0:7];
    longint      p[0:7];
    longint      first_half[0:7];
    longint      second_half[0:7];
    longint      d[0:1];
    longint      h12, h23, h34, h123, h234, hm, h14;
    logic [63:0] tol_w;
    logic [63:0] qt;
    int          depth;
    int          lvl;
    int          b;
    tol_w = {48'b0, c.tolerance} << cbf_pkg::GUARD_BITS;
    qt    = tol_w * tol_w;
    // slots 0..3 hold x, slots 4..7 hold y
    pieces[0][0] = longint'($signed(c.x1)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][1] = longint'($signed(c.x2)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][2] = longint'($signed(c.x3)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][3] = longint'($signed(c.x4)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][4] = longint'($signed(c.y1)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][5] = longint'($signed(c.y2)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][6] = longint'($signed(c.y3)) <<< cbf_pkg::GUARD_BITS;
    pieces[0][7] = longint'($signed(c.y4)) <<< cbf_pkg::GUARD_BITS;
    levels[0] = 0;
    depth = 1;
    while (depth > 0) begin
      depth--;
      for (int k = 0; k < 8; k++) p[k] = pieces[depth][k];
      lvl = levels[depth];
      // emit leaves past the depth limit untested
      if (lvl > cbf_pkg::MAX_DEPTH) begin
        pending_points.push_back(
          cbf_pkg::out_item_t'({drop_guard(p[3]), drop_guard(p[7]), 1'b0}));
        continue;
      end
      for (int a = 0; a < 2; a++) begin
        b = 4 * a;
        h12  = mid_floor(p[b], p[b+1]);
        h23  = mid_floor(p[b+1], p[b+2]);
        h34  = mid_floor(p[b+2], p[b+3]);
        h123 = mid_floor(h12, h23);
        h234 = mid_floor(h23, h34);
        hm   = mid_floor(h123, h234);
        h14  = mid_floor(p[b], p[b+3]);
        d[a] = h14 - hm;
        first_half[b]    = p[b];
        first_half[b+1]  = h12;
        first_half[b+2]  = h123;
        first_half[b+3]  = hm;
        second_half[b]   = hm;
        second_half[b+1] = h234;
        second_half[b+2] = h34;
        second_half[b+3] = p[b+3];
      end
      if (within_tol(d[0], d[1], qt)) begin
        pending_points.push_back(
          cbf_pkg::out_item_t'({drop_guard(p[3]), drop_guard(p[7]), 1'b0}));
        continue;
      end
      // second half below, first half on top
      for (int k = 0; k < 8; k++) pieces[depth][k] = second_half[k];
      levels[depth] = lvl + 1;
      for (int k = 0; k < 8; k++) pieces[depth+1][k] = first_half[k];
      levels[depth+1] = lvl + 1;
      depth += 2;
    end
    pending_points.push_back(cbf_pkg::out_item_t'({c.x4, c.y4, 1'b1}));
  endfunction

  function automatic cbf_pkg::in_item_t curve_of(input int x1, input int y1, input int x2,
                                                 input int y2, input int x3, input int y3,
                                                 input int x4, input int y4,
                                                 input int tol);
    cbf_pkg::in_item_t c;
    c.x1 = x1[cbf_pkg::COORD_BITS-1:0];
    c.y1 = y1[cbf_pkg::COORD_BITS-1:0];
    c.x2 = x2[cbf_pkg::COORD_BITS-1:0];
    c.y2 = y2[cbf_pkg::COORD_BITS-1:0];
    c.x3 = x3[cbf_pkg::COORD_BITS-1:0];
    c.y3 = y3[cbf_pkg::COORD_BITS-1:0];
    c.x4 = x4[cbf_pkg::COORD_BITS-1:0];
    c.y4 = y4[cbf_pkg::COORD_BITS-1:0];
    c.tolerance = tol[cbf_pkg::TOL_BITS-1:0];
    return c;
  endfunction

  // Mostly local curves with a tolerance near their bend, plus noise
  function automatic cbf_pkg::in_item_t random_curve();
    cbf_pkg::in_item_t c;
    int kind;
    int span;
    int bx;
    int by;
    int t;
    kind = $urandom_range(99);
    if (kind < 15) begin
      // full range on every field
      c.x1 = cbf_pkg::COORD_BITS'($urandom);
      c.y1 = cbf_pkg::COORD_BITS'($urandom);
      c.x2 = cbf_pkg::COORD_BITS'($urandom);
      c.y2 = cbf_pkg::COORD_BITS'($urandom);
      c.x3 = cbf_pkg::COORD_BITS'($urandom);
      c.y3 = cbf_pkg::COORD_BITS'($urandom);
      c.x4 = cbf_pkg::COORD_BITS'($urandom);
      c.y4 = cbf_pkg::COORD_BITS'($urandom);
      c.tolerance = cbf_pkg::TOL_BITS'($urandom);
    end else if (kind < 92) begin
      span = 1 << $urandom_range(2, 20);
      bx = $urandom;
      by = $urandom;
      c.x1 = cbf_pkg::COORD_BITS'(bx + $urandom_range(0, 2 * span) - span);
      c.y1 = cbf_pkg::COORD_BITS'(by + $urandom_range(0, 2 * span) - span);
      c.x2 = cbf_pkg::COORD_BITS'(bx + $urandom_range(0, 2 * span) - span);
      c.y2 = cbf_pkg::COORD_BITS'(by + $urandom_range(0, 2 * span) - span);
      c.x3 = cbf_pkg::COORD_BITS'(bx + $urandom_range(0, 2 * span) - span);
      c.y3 = cbf_pkg::COORD_BITS'(by + $urandom_range(0, 2 * span) - span);
      c.x4 = cbf_pkg::COORD_BITS'(bx + $urandom_range(0, 2 * span) - span);
      c.y4 = cbf_pkg::COORD_BITS'(by + $urandom_range(0, 2 * span) - span);
      t = span >> $urandom_range(0, 12);
      if (t > 65535) t = 65535;
      if ($urandom_range(19) == 0) t = 0;
      c.tolerance = cbf_pkg::TOL_BITS'(t);
    end else begin
      // degenerate: every point the same
      c.x1 = cbf_pkg::COORD_BITS'($urandom);
      c.y1 = cbf_pkg::COORD_BITS'($urandom);
      c.x2 = c.x1;
      c.y2 = c.y1;
      c.x3 = c.x1;
      c.y3 = c.y1;
      c.x4 = c.x1;
      c.y4 = c.y1;
      c.tolerance = ($urandom_range(3) == 0) ? '0 : cbf_pkg::TOL_BITS'($urandom);
    end
    return c;
  endfunction

  // Offer one curve, hold it until taken, then queue what it should give
  task automatic offer_curve(input cbf_pkg::in_item_t c, input logic typed);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= c;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (typed) begin
      // a flat piece at once: the end point, then the end point flagged last
      pending_points.push_back(cbf_pkg::out_item_t'({c.x4, c.y4, 1'b0}));
      pending_points.push_back(cbf_pkg::out_item_t'({c.x4, c.y4, 1'b1}));
    end else begin
      flatten_curve(c);
    end
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int held;
    held = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (held < hold_req) begin
        held++;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Check each accepted endpoint against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected endpoint x=%0d y=%0d last=%0b",
                   out_data.point_x, out_data.point_y, out_data.last);
      end else begin
        want = pending_points.pop_front();
        if (out_data.point_x !== want.point_x || out_data.point_y !== want.point_y ||
            out_data.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: x exp %0d got %0d, y exp %0d got %0d, last exp %0b got %0b",
                     want.point_x, out_data.point_x, want.point_y, out_data.point_y,
                     want.last, out_data.last);
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    idle_pct  = 0;
    stall_pct = 0;
    hold_req  = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;

    // degenerate rows with nonzero tolerance have their results typed in
    directed_rows[0]  = {curve_of(0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1};
    directed_rows[1]  = {curve_of(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
                                  'hFFFF), 1'b1};
    directed_rows[2]  = {curve_of(MINC, MINC, MINC, MINC, MINC, MINC, MINC, MINC, 1), 1'b1};
    directed_rows[3]  = {curve_of(-1, -1, -1, -1, -1, -1, -1, -1, 'h8000), 1'b1};
    directed_rows[4]  = {curve_of(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0};
    directed_rows[5]  = {curve_of(0, 0, 25600, 51200, 51200, -51200, 76800, 0, 0), 1'b0};
    directed_rows[6]  = {curve_of(MINC, MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC,
                                  'hFFFF), 1'b0};
    directed_rows[7]  = {curve_of(MINC, MAXC, MAXC, MINC, MINC, MAXC, MAXC, MINC, 1), 1'b0};
    directed_rows[8]  = {curve_of(MAXC, MINC, MAXC, MINC, MINC, MAXC, MINC, MAXC,
                                  'hFFFF), 1'b0};
    directed_rows[9]  = {curve_of(0, 0, 256, 256, 512, 512, 768, 768, 1), 1'b0};
    directed_rows[10] = {curve_of(0, 0, 2560, 10240, 7680, 10240, 10240, 0, 256), 1'b0};
    directed_rows[11] = {curve_of('h555555, 'hAAAAAA, 'hAAAAAA, 'h555555, 'h555555,
                                  'hAAAAAA, 'hAAAAAA, 'h555555, 'h5555), 1'b0};
    directed_rows[12] = {curve_of('hAAAAAA, 'h555555, 'h555555, 'hAAAAAA, 'hAAAAAA,
                                  'h555555, 'h555555, 'hAAAAAA, 'hAAAA), 1'b0};
    directed_rows[13] = {curve_of(-1000, -1000, -500, 3000, 1500, -3000, 1000, 1000, 16),
                         1'b0};
    directed_rows[14] = {curve_of(100, 200, 100, 200, 100, 200, 300, 400, 1), 1'b0};
    directed_rows[15] = {curve_of(1, 1, -1, -1, 1, 1, -1, -1, 0), 1'b0};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table with no idling
    for (int i = 0; i < NUM_ROWS; i++)
      offer_curve(directed_rows[i].curve, directed_rows[i].typed);
    drain_points();

    // random curves, one phase of gaps and stalls at a time
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      // hold the receiver off for a long stretch while curves keep coming
      if (ph == 2) hold_req = HOLD_CYCLES;
      for (int n = 0; n < PHASE_ITEMS; n++)
        offer_curve(random_curve(), 1'b0);
      drain_points();
    end

    repeat (40) @(posedge clk);
    if (pending_points.size() != 0)
      $display("%0d endpoints never arrived", pending_points.size());
    if (mismatch_count == 0 && pending_points.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// File: cubic_bezier_flattener.f
rtl/cbf_pkg.sv
rtl/cbf_stack.sv
rtl/cbf_unit.sv
rtl/cbf_seq.sv
rtl/cubic_bezier_flattener.sv
tb/sv/cubic_bezier_flattener_tb.sv
